// ===== rtl/eipc_pkg.sv =====
package eipc_pkg;

  localparam logic [15:0] TYPE_VLAN_Q  = 16'h8100;
  localparam logic [15:0] TYPE_VLAN_AD = 16'h88A8;
  localparam logic [15:0] TYPE_IPV4    = 16'h0800;
  localparam logic [15:0] TYPE_IPV6    = 16'h86DD;

  localparam logic [5:0] POS_MAX      = 6'd63;
  localparam logic [4:0] ETH_HDR_LEN  = 5'd14;
  localparam logic [4:0] VLAN_TAG_LEN = 5'd4;
  localparam logic [1:0] MAX_TAGS     = 2'd2;
  localparam logic [5:0] IPV4_PROTO   = 6'd9;
  localparam logic [5:0] IPV6_NEXT    = 6'd6;
  localparam logic [5:0] IPV4_HDR_LEN = 6'd20;
  localparam logic [5:0] IPV6_HDR_LEN = 6'd40;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int NUM_KEYS    = 256;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  protocol_key;
    logic        was_counted;
    logic [31:0] new_count;
  } out_word_t;

  typedef struct packed {
    logic [7:0] key;
    logic       counted;
  } job_t;

endpackage

// ===== rtl/ethernet_ip_protocol_counter.sv =====
// after its last byte is taken, a frame's job passes through the queue, the read stage and the output register
// throughput: one byte per cycle while in_stall is low, frames of any length back to back
// the counter stage retires one frame per cycle while out_stall is low, fed by a 4-entry queue
// reset: synchronous active-low rst_n clears the parser, queue and pipeline
// all 256 counters read as zero after reset through per-entry live bits
module ethernet_ip_protocol_counter #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  eipc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output eipc_pkg::out_word_t out_data
);
  import eipc_pkg::*;

  logic in_accept;
  logic push, pop, q_nempty, q_full;
  job_t push_job, head_job;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  eipc_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .word     (in_data),
    .push     (push),
    .push_job (push_job)
  );

  eipc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .nempty   (q_nempty),
    .full     (q_full)
  );

  eipc_count #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_nempty  (q_nempty),
    .q_head    (head_job),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/eipc_parser.sv =====
module eipc_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  eipc_pkg::in_word_t word,
  output logic             push,
  output eipc_pkg::job_t   push_job
);
  import eipc_pkg::*;

  logic [5:0]  pos_r, pos_nxt;
  logic [15:0] et_r, et_nxt;
  logic [1:0]  tags_r, tags_nxt;
  logic [4:0]  ns_r, ns_nxt;
  logic [7:0]  fp_r, fp_nxt;
  logic [5:0]  ns6, ns6_nxt;
  logic        short_hdr;

  always_comb begin
    et_nxt   = et_r;
    tags_nxt = tags_r;
    ns_nxt   = ns_r;
    fp_nxt   = fp_r;
    ns6      = {1'b0, ns_r};
    if (pos_r == ns6 - 6'd2) begin
      et_nxt = {word.frame_byte, 8'h00};
    end else if (pos_r == ns6 - 6'd1) begin
      et_nxt = {et_r[15:8], word.frame_byte};
      if ((et_nxt == TYPE_VLAN_Q || et_nxt == TYPE_VLAN_AD) && tags_r < MAX_TAGS) begin
        tags_nxt = tags_r + 2'd1;
        ns_nxt   = ns_r + VLAN_TAG_LEN;
      end
    end else if (pos_r >= ns6) begin
      if (et_r == TYPE_IPV4 && pos_r == ns6 + IPV4_PROTO) begin
        fp_nxt = word.frame_byte;
      end else if (et_r == TYPE_IPV6 && pos_r == ns6 + IPV6_NEXT) begin
        fp_nxt = word.frame_byte;
      end
    end
    pos_nxt = (pos_r < POS_MAX) ? pos_r + 6'd1 : pos_r;
  end

  // classify on the final byte
  always_comb begin
    ns6_nxt   = {1'b0, ns_nxt};
    short_hdr = pos_nxt < ns6_nxt;
    push      = accept && word.frame_end;
    push_job.counted = !short_hdr;
    push_job.key     = 8'h00;
    if (!short_hdr) begin
      if (et_nxt == TYPE_IPV4 && pos_nxt >= ns6_nxt + IPV4_HDR_LEN) begin
        push_job.key = fp_nxt;
      end else if (et_nxt == TYPE_IPV6 && pos_nxt >= ns6_nxt + IPV6_HDR_LEN) begin
        push_job.key = fp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && word.frame_end)) begin
      pos_r  <= '0;
      et_r   <= '0;
      tags_r <= '0;
      ns_r   <= ETH_HDR_LEN;
      fp_r   <= '0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      et_r   <= et_nxt;
      tags_r <= tags_nxt;
      ns_r   <= ns_nxt;
      fp_r   <= fp_nxt;
    end
  end

endmodule

// ===== rtl/eipc_queue.sv =====
module eipc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  eipc_pkg::job_t push_job,
  input  logic           pop,
  output eipc_pkg::job_t head_job,
  output logic           nempty,
  output logic           full
);
  import eipc_pkg::*;

  job_t                  slots_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]     fill_r, fill_nxt;

  assign nempty   = fill_r != '0;
  assign full     = fill_r == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign head_job = slots_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (QUEUE_AW+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !nempty |-> !pop)
    else $error("queue pop while empty");
`endif

endmodule

// ===== rtl/eipc_count.sv =====
module eipc_count #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_nempty,
  input  eipc_pkg::job_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output eipc_pkg::out_word_t out_data
);
  import eipc_pkg::*;

  logic [COUNTER_WIDTH-1:0] mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]      live_r;

  logic                     s1_vld_r;
  job_t                     s1_job_r;
  logic [COUNTER_WIDTH-1:0] rd_r;
  logic                     rd_live_r;
  logic                     fwd_hit_r;
  logic [COUNTER_WIDTH-1:0] fwd_val_r;

  logic                     out_vld_r;
  out_word_t                out_r;

  logic                     s1_adv;
  logic                     wr_en;
  logic [COUNTER_WIDTH-1:0] old_cnt, cnt;
  logic [63:0]              cnt_ext;
  out_word_t                out_nxt;

  assign s1_adv = s1_vld_r && (!out_vld_r || !out_stall);
  assign q_pop  = q_nempty && (!s1_vld_r || s1_adv);
  assign wr_en  = s1_adv && s1_job_r.counted;

  always_comb begin
    old_cnt = fwd_hit_r ? fwd_val_r : (rd_live_r ? rd_r : '0);
    cnt     = old_cnt + COUNTER_WIDTH'(1);
    cnt_ext = 64'(cnt);
    out_nxt.protocol_key = s1_job_r.key;
    out_nxt.was_counted  = s1_job_r.counted;
    out_nxt.new_count    = s1_job_r.counted ? cnt_ext[31:0] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        live_r[s1_job_r.key] <= 1'b1;
      end
      if (q_pop) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // counter store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_job_r.key] <= cnt;
    end
    if (q_pop) begin
      rd_r <= mem[q_head.key];
    end
  end

  // read stage, with bypass of a write to the same key in that cycle
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_job_r  <= q_head;
      rd_live_r <= live_r[q_head.key];
      fwd_hit_r <= wr_en && (s1_job_r.key == q_head.key);
      fwd_val_r <= cnt;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_uncounted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_r.was_counted |-> out_r.new_count == 32'd0 &&
      out_r.protocol_key == 8'h00)
    else $error("uncounted word with nonzero fields");
  a_write_marks_live: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> live_r[$past(s1_job_r.key)])
    else $error("counter written without live bit");
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_adv |=> s1_vld_r && $stable(s1_job_r))
    else $error("read stage lost a job while blocked");
`endif

endmodule
